[src/fsba_pkg.sv]
package fsba_pkg;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd2;

  localparam logic REG_ELEM_SIZE  = 1'b0;
  localparam logic REG_ADDR_LIMIT = 1'b1;

  localparam int ELEM_SIZE_W  = 17;
  localparam int ADDR_LIMIT_W = 32;
  localparam int OUT_ADDR_W   = 32;
  localparam int FREE_CNT_W   = 9;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] address;
    logic [1:0]            status;
    logic [FREE_CNT_W-1:0] free_count;
  } res_t;

endpackage

[src/fsba_ram.sv]
module fsba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/fsba_resq.sv]
module fsba_resq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fsba_pkg::res_t push_data,
  input  logic          pop_ready,
  output logic          head_valid,
  output fsba_pkg::res_t head_data,
  output logic          full
);

  import fsba_pkg::*;

  logic hv_r, hv_nxt;
  logic sv_r, sv_nxt;
  res_t head_r, head_nxt;
  res_t skid_r, skid_nxt;
  logic pop;

  assign pop = hv_r && pop_ready;

  always_comb begin
    hv_nxt   = hv_r;
    sv_nxt   = sv_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    if (pop) begin
      if (sv_r) begin
        head_nxt = skid_r;
        hv_nxt   = 1'b1;
        sv_nxt   = push;
        skid_nxt = push_data;
      end else begin
        head_nxt = push_data;
        hv_nxt   = push;
      end
    end else if (push) begin
      if (!hv_r) begin
        head_nxt = push_data;
        hv_nxt   = 1'b1;
      end else begin
        skid_nxt = push_data;
        sv_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      hv_r <= hv_nxt;
      sv_r <= sv_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign head_valid = hv_r;
  assign head_data  = head_r;
  assign full       = sv_r;

endmodule

[src/free_stack_bump_allocator.sv]
// Channel   Direction  Transaction                    Payload
// in_       slave      in_tvalid & in_tready          tuser action, tdata free_address
// out_      master     out_tvalid & out_tready        tuser status, tdata address/free_count
// cfg_      APB        psel & penable & pwrite        element_size at 0, address_limit at 4
//
// A free, or an allocate served from the bump pointer, pushes its result in the cycle it is accepted.
// An allocate that pops the free stack starts a registered stack read in S_IDLE and
// pushes its result from S_POP, where no new transaction is accepted.
// Reset clears the stack count and the bump pointer and returns the configuration
// registers to their default values.
// A two-entry result queue lets one more transaction enter while a result is stalled.
module free_stack_bump_allocator #(
  parameter int ADDR_BITS   = 32,
  parameter int STACK_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // [31:0] free_address
  input  logic        in_tuser,     // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,    // [31:0] address, [40:32] free_count, [47:41] zero
  output logic [1:0]  out_tuser,    // [1:0] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  import fsba_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int SUM_W = ((ADDR_BITS > ELEM_SIZE_W) ? ADDR_BITS : ELEM_SIZE_W) + 1;
  localparam int CMP_W = (ADDR_BITS > ADDR_LIMIT_W) ? ADDR_BITS : ADDR_LIMIT_W;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [ADDR_BITS-1:0]    bump_r, bump_nxt;
  logic [ELEM_SIZE_W-1:0]  elem_size_r;
  logic [ADDR_LIMIT_W-1:0] limit_r;

  logic                 in_acc;
  logic                 stack_full;
  logic                 stack_empty;
  logic [CNT_W-1:0]     top_idx;
  logic [SUM_W-1:0]     bump_sum;
  logic                 bump_refused;
  logic                 ram_we;
  logic                 ram_re;
  logic [ADDR_BITS-1:0] ram_rdata;
  logic                 push;
  res_t                 res;
  logic                 q_full;
  res_t                 head;
  logic                 cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_paddr[2])
      REG_ELEM_SIZE:  cfg_prdata = 32'(elem_size_r);
      REG_ADDR_LIMIT: cfg_prdata = limit_r;
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_size_r <= ELEM_SIZE_W'(16);
      limit_r     <= '1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_ELEM_SIZE:  elem_size_r <= cfg_pwdata[ELEM_SIZE_W-1:0];
        REG_ADDR_LIMIT: limit_r     <= cfg_pwdata;
        default:        ;
      endcase
    end
  end

  assign in_tready   = (state_r == S_IDLE) && !q_full;
  assign in_acc      = in_tvalid && in_tready;
  assign stack_full  = (count_r == CNT_W'(STACK_DEPTH));
  assign stack_empty = (count_r == '0);
  assign top_idx     = count_r - 1'b1;
  assign bump_sum    = SUM_W'(bump_r) + SUM_W'(elem_size_r);
  assign bump_refused = (CMP_W'(bump_r) > CMP_W'(limit_r)) || (|bump_sum[SUM_W-1:ADDR_BITS]);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == ACT_ALLOC) && !stack_empty) begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    push      = 1'b0;
    count_nxt = count_r;
    bump_nxt  = bump_r;
    res       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == ACT_FREE) begin
            push = 1'b1;
            if (stack_full) begin
              res.status = STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end else if (!stack_empty) begin
            ram_re    = 1'b1;
            count_nxt = top_idx;
          end else begin
            push = 1'b1;
            if (bump_refused) begin
              res.status = STAT_EXHAUSTED;
            end else begin
              res.address = OUT_ADDR_W'(bump_r);
              bump_nxt    = bump_sum[ADDR_BITS-1:0];
            end
          end
        end
      end
      S_POP: begin
        push        = 1'b1;
        res.address = OUT_ADDR_W'(ram_rdata);
      end
      default: ;
    endcase
    res.free_count = FREE_CNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      bump_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      bump_r  <= bump_nxt;
    end
  end

  fsba_ram #(
    .WIDTH (ADDR_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (ADDR_BITS'(in_tdata)),
    .re    (ram_re),
    .raddr (top_idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  fsba_resq u_resq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (res),
    .pop_ready  (out_tready),
    .head_valid (out_tvalid),
    .head_data  (head),
    .full       (q_full)
  );

  assign out_tdata = {7'd0, head.free_count, head.address};
  assign out_tuser = head.status;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("Free stack count exceeds its depth.");

  a_pop_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |=> state_r == S_IDLE)
    else $error("Stack pop did not finish in one cycle.");

  a_bump_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> bump_r >= $past(bump_r))
    else $error("Bump pointer moved backward.");

  a_free_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == ACT_FREE && !stack_full |=> count_r == $past(count_r) + 1'b1)
    else $error("Accepted free did not grow the stack.");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !(q_full && !(out_tvalid && out_tready)))
    else $error("Result pushed into a full queue.");

endmodule
